### design/nse_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the NMEA sentence field extractor.
// No dependencies; the top level, nse_front and nse_back import this package.
package nse_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_A      = 8'h41;

    // Header letters sit at 3..5; HEADER_END is the first character after the header.
    localparam logic [6:0] HEADER_FIRST = 7'd3;
    localparam logic [6:0] HEADER_MID   = 7'd4;
    localparam logic [6:0] HEADER_LAST  = 7'd5;
    localparam logic [6:0] HEADER_END   = 7'd6;

    localparam logic [23:0] TYPE_RESET = {CH_G, CH_G, CH_A};
    localparam logic [31:0] MASK_RESET = 32'd638;

    localparam int          CFG_IDX_W         = 2;
    localparam logic [1:0]  CFG_SENTENCE_TYPE = 2'd0;
    localparam logic [1:0]  CFG_FIELD_MASK    = 2'd1;

    localparam logic [4:0]  COUNT_MAX = 5'd31;

    // One record handed from the front end to the back end.
    typedef struct packed {
        logic       is_end;
        logic [4:0] field;
        logic [4:0] pos;
        logic [7:0] ch;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

endpackage

### design/nmea_sentence_field_extractor.sv
`timescale 1ns / 1ps
// NMEA sentence field extractor, top level. Instantiates nse_front, nse_fifo
// and nse_back, and holds the two configuration registers. Uses nse_pkg.
//
// Usage:
// The input channel takes one received byte per transaction (i_valid,
// o_stall, i_char_in). A '$' opens a sentence; characters 3 to 5 are matched
// against the sentence_type register. In a matching sentence every character
// of a comma field enabled in field_mask leaves as one output transaction
// (o_valid, i_stall) with its field number and position in the field, and a
// '*' or CR closes the sentence with an end record (o_sentence_end = 1).
// Characters past the field limit carry the last index and o_field_overflow.
//
// The front end updates the sentence state in the cycle a byte is taken and
// pushes a candidate record into a four-entry queue. The back end pops one
// record per cycle while the output is not stalled, applies the field mask
// and loads the output register. A result passes through the queue and the
// output register before it is shown. The block takes one byte every cycle;
// o_stall rises only when the queue is full, which happens only while the
// receiver holds i_stall. Output data hold steady under stall.
//
// Reset (i_rst_n low, synchronous) empties the queue and output register,
// leaves no sentence open and loads sentence_type with GGA and field_mask
// with fields 1 to 6 and 9. The configuration port is always ready; the user
// must write it only while no transaction is in flight; the block does not enforce this.
module nmea_sentence_field_extractor #(
    parameter int MAX_FIELD_CHARS    = 16,
    parameter int MAX_SENTENCE_CHARS = 128
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input byte channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_char_in,
    // result channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [4:0]                o_field_number,
    output logic [3:0]                o_char_index,
    output logic [7:0]                o_char_value,
    output logic                      o_sentence_end,
    output logic                      o_field_overflow,
    // configuration write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [nse_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]               i_cfg_data
);
    import nse_pkg::*;

    localparam int QUEUE_DEPTH = 4;

    logic [23:0] r_sentence_type;
    logic [31:0] r_field_mask;

    logic        in_accept;
    logic        push;
    t_rec        push_rec;
    logic [REC_W-1:0] pop_bits;
    t_rec        pop_rec;
    logic        pop;
    logic        q_full;
    logic        q_nonempty;

    // Configuration registers; writes to indexes beyond the list are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sentence_type <= TYPE_RESET;
            r_field_mask    <= MASK_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SENTENCE_TYPE: r_sentence_type <= i_cfg_data[23:0];
                CFG_FIELD_MASK:    r_field_mask    <= i_cfg_data;
                default:           r_field_mask    <= r_field_mask;
            endcase
        end
    end

    // The input side stalls only when the queue has no free entry.
    assign o_stall   = q_full;
    assign in_accept = i_valid && !o_stall;

    nse_front #(
        .MAX_SENTENCE_CHARS(MAX_SENTENCE_CHARS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_char_in      (i_char_in),
        .i_sentence_type(r_sentence_type),
        .o_push         (push),
        .o_rec          (push_rec)
    );

    nse_fifo #(
        .WIDTH(REC_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_data    (push_rec),
        .i_pop     (pop),
        .o_data    (pop_bits),
        .o_full    (q_full),
        .o_nonempty(q_nonempty)
    );

    assign pop_rec = t_rec'(pop_bits);

    nse_back #(
        .MAX_FIELD_CHARS(MAX_FIELD_CHARS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rec_valid     (q_nonempty),
        .i_rec           (pop_rec),
        .i_field_mask    (r_field_mask),
        .i_stall         (i_stall),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .o_field_number  (o_field_number),
        .o_char_index    (o_char_index),
        .o_char_value    (o_char_value),
        .o_sentence_end  (o_sentence_end),
        .o_field_overflow(o_field_overflow)
    );

endmodule

### design/nse_fifo.sv
`timescale 1ns / 1ps
// Small register queue between the front end and the back end.
// Generic width and depth; no package dependency.
module nse_fifo #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_nonempty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data     = r_mem[r_rd_ptr];
    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_nonempty = (r_count != '0);

endmodule

### design/nse_front.sv
`timescale 1ns / 1ps
// Front end: tracks sentence framing, header match and comma fields.
// Produces a record per candidate character or end of sentence. Uses nse_pkg.
module nse_front #(
    parameter int MAX_SENTENCE_CHARS = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_char_in,
    input  logic [23:0]   i_sentence_type,
    output logic          o_push,
    output nse_pkg::t_rec o_rec
);
    import nse_pkg::*;

    localparam int SENTENCE_LIMIT = (MAX_SENTENCE_CHARS < 127) ? MAX_SENTENCE_CHARS : 127;
    localparam logic [6:0] POS_LIMIT = 7'(SENTENCE_LIMIT);

    logic [6:0] r_sent_pos, n_sent_pos;
    logic [4:0] r_comma, n_comma;
    logic [4:0] r_field_pos, n_field_pos;
    logic       r_hdr_ok, n_hdr_ok;
    logic       r_inside, n_inside;
    logic [7:0] want;

    always_comb begin
        case (r_sent_pos)
            HEADER_FIRST: want = i_sentence_type[23:16];
            HEADER_MID:   want = i_sentence_type[15:8];
            default:      want = i_sentence_type[7:0];
        endcase
    end

    always_comb begin
        n_sent_pos  = r_sent_pos;
        n_comma     = r_comma;
        n_field_pos = r_field_pos;
        n_hdr_ok    = r_hdr_ok;
        n_inside    = r_inside;
        o_push      = 1'b0;
        o_rec       = '{is_end: 1'b0, field: r_comma, pos: r_field_pos, ch: i_char_in};
        if (i_accept) begin
            if (i_char_in == CH_DOLLAR) begin
                n_inside    = 1'b1;
                n_sent_pos  = 7'd1;
                n_comma     = '0;
                n_field_pos = '0;
                n_hdr_ok    = 1'b1;
            end else if (r_inside) begin
                if (r_sent_pos >= POS_LIMIT) begin
                    n_inside = 1'b0;
                end else begin
                    n_sent_pos = r_sent_pos + 1'b1;
                    if (i_char_in == CH_STAR || i_char_in == CH_CR) begin
                        n_inside = 1'b0;
                        if (r_hdr_ok && r_sent_pos >= HEADER_END) begin
                            o_push       = 1'b1;
                            o_rec.is_end = 1'b1;
                            o_rec.pos    = '0;
                        end
                    end else if (r_sent_pos >= HEADER_FIRST && r_sent_pos <= HEADER_LAST) begin
                        if (i_char_in != want) begin
                            n_hdr_ok = 1'b0;
                        end
                    end else if (r_sent_pos < HEADER_END) begin
                        n_hdr_ok = r_hdr_ok;
                    end else if (i_char_in == CH_COMMA) begin
                        if (r_comma != COUNT_MAX) begin
                            n_comma = r_comma + 1'b1;
                        end
                        n_field_pos = '0;
                    end else begin
                        o_push = r_hdr_ok;
                        if (r_field_pos != COUNT_MAX) begin
                            n_field_pos = r_field_pos + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent_pos  <= '0;
            r_comma     <= '0;
            r_field_pos <= '0;
            r_hdr_ok    <= 1'b1;
            r_inside    <= 1'b0;
        end else begin
            r_sent_pos  <= n_sent_pos;
            r_comma     <= n_comma;
            r_field_pos <= n_field_pos;
            r_hdr_ok    <= n_hdr_ok;
            r_inside    <= n_inside;
        end
    end

endmodule

### design/nse_back.sv
`timescale 1ns / 1ps
// Back end: applies the field mask and the field length limit to queued
// records and holds the result in the output register. Uses nse_pkg.
module nse_back #(
    parameter int MAX_FIELD_CHARS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rec_valid,
    input  nse_pkg::t_rec i_rec,
    input  logic [31:0]   i_field_mask,
    input  logic          i_stall,
    output logic          o_pop,
    output logic          o_valid,
    output logic [4:0]    o_field_number,
    output logic [3:0]    o_char_index,
    output logic [7:0]    o_char_value,
    output logic          o_sentence_end,
    output logic          o_field_overflow
);
    import nse_pkg::*;

    localparam int FIELD_LIMIT = (MAX_FIELD_CHARS < 16) ? MAX_FIELD_CHARS : 16;
    localparam logic [4:0] POS_LIMIT = 5'(FIELD_LIMIT);
    localparam logic [3:0] IDX_SAT   = 4'(FIELD_LIMIT - 1);

    logic r_valid, n_valid;
    logic selected;
    logic ovf;

    assign selected = i_rec.is_end || i_field_mask[i_rec.field];
    assign ovf      = !i_rec.is_end && (i_rec.pos >= POS_LIMIT);
    assign o_pop    = i_rec_valid && (!r_valid || !i_stall);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = selected;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (o_pop && selected) begin
            o_field_number   <= i_rec.field;
            o_char_index     <= ovf ? IDX_SAT : i_rec.pos[3:0];
            o_char_value     <= i_rec.ch;
            o_sentence_end   <= i_rec.is_end;
            o_field_overflow <= ovf;
        end
    end

    assign o_valid = r_valid;

endmodule

### design/nse_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the NMEA sentence field extractor, with the bind
// that attaches them to the top level. Depends on the top level's ports.
module nse_checker #(
    parameter int MAX_FIELD_CHARS = 16
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [4:0] o_field_number,
    input logic [3:0] o_char_index,
    input logic [7:0] o_char_value,
    input logic       o_sentence_end,
    input logic       o_field_overflow
);
    localparam int FIELD_LIMIT = (MAX_FIELD_CHARS < 16) ? MAX_FIELD_CHARS : 16;
    localparam logic [3:0] IDX_SAT = 4'(FIELD_LIMIT - 1);

    // A stalled result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_field_number)
            && $stable(o_char_index) && $stable(o_char_value)
            && $stable(o_sentence_end) && $stable(o_field_overflow))
        else $error("result changed while stalled");

    // End records carry a zero index and no overflow flag.
    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sentence_end |-> !o_field_overflow && o_char_index == 4'd0)
        else $error("end record with index or overflow set");

    // End records carry the terminator that closed the sentence.
    a_end_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sentence_end |-> (o_char_value == 8'h2A || o_char_value == 8'h0D))
        else $error("end record without a terminator character");

    // An overflowing character sits at the last index of the field.
    a_ovf_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_field_overflow |-> o_char_index == IDX_SAT)
        else $error("overflow flag with an unsaturated index");

endmodule

bind nmea_sentence_field_extractor nse_checker #(
    .MAX_FIELD_CHARS(MAX_FIELD_CHARS)
) u_nse_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_field_number  (o_field_number),
    .o_char_index    (o_char_index),
    .o_char_value    (o_char_value),
    .o_sentence_end  (o_sentence_end),
    .o_field_overflow(o_field_overflow)
);
